>>> sv/bbsf_pkg.sv
// shared types and constants for the bounded byte stream fifo
package bbsf_pkg;

	localparam int CAPACITY_MAX = 64;
	localparam int ADDR_W       = $clog2(CAPACITY_MAX);
	localparam int CNT_W        = $clog2(CAPACITY_MAX + 1);
	localparam int CFG_W        = 7;
	localparam int LEN_W        = 7;
	localparam int TOT_W        = 64;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_PEEK  = 3'd1,
		ACT_POP   = 3'd2,
		ACT_READ  = 3'd3,
		ACT_END   = 3'd4,
		ACT_QUERY = 3'd5
	} bbsf_action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_CLOSED    = 3'd2,
		ST_STICKY    = 3'd3,
		ST_UNDERFLOW = 3'd4
	} bbsf_status_t;

	typedef struct packed {
		logic [2:0]       action;
		logic [7:0]       byte_in;
		logic [LEN_W-1:0] length;
	} bbsf_cmd_t;

	typedef struct packed {
		logic [7:0]       byte_out;
		logic             byte_valid;
		logic             last;
		logic [2:0]       status;
		logic [6:0]       occupancy;
		logic [6:0]       space_left;
		logic [TOT_W-1:0] total_written;
		logic [TOT_W-1:0] total_read;
		logic             input_closed;
		logic             end_of_stream;
		logic             error_flag;
	} bbsf_result_t;

	// one classified request waiting for the back end
	typedef struct packed {
		logic              run;
		logic              is_read;
		logic [ADDR_W-1:0] start;
		logic [CNT_W-1:0]  n;
		logic [2:0]        status;
		logic [6:0]        occupancy;
		logic [6:0]        space_left;
		logic [TOT_W-1:0]  total_written;
		logic [TOT_W-1:0]  total_read;
		logic              input_closed;
		logic              end_of_stream;
		logic              error_flag;
	} bbsf_job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} bbsf_wr_t;

	typedef struct packed {
		logic read_done;
	} bbsf_back_stat_t;

endpackage

>>> sv/bbsf_queue.sv
// two-entry job queue between front and back
module bbsf_queue import bbsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bbsf_job_t push_job,
	input  logic      pop,
	output bbsf_job_t head_job,
	output logic      not_empty,
	output logic      full
);

	bbsf_job_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign head_job  = entry_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> sv/bbsf_front.sv
// front end: takes requests, keeps the fifo bookkeeping, queues jobs
module bbsf_front import bbsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bbsf_cmd_t        cmd,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             q_full,
	input  bbsf_back_stat_t  back_stat,
	output logic             busy,
	output logic             push,
	output bbsf_job_t        job,
	output bbsf_wr_t         wr
);

	logic [CFG_W-1:0]  cap_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TOT_W-1:0]  wtot_q;
	logic [TOT_W-1:0]  rtot_q;
	logic              closed_q;
	logic              err_q;
	logic              lock_q;

	logic [ADDR_W-1:0] head_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [TOT_W-1:0]  wtot_n;
	logic [TOT_W-1:0]  rtot_n;
	logic              closed_n;
	logic              err_n;
	logic              lock_set;
	logic [CNT_W-1:0]  eff_cap;
	logic [CNT_W-1:0]  len;
	logic [CNT_W-1:0]  peek_n;

	assign busy    = q_full || lock_q;
	assign push    = start && !busy;
	assign eff_cap = (cap_q > CFG_W'(CAPACITY_MAX)) ? CNT_W'(CAPACITY_MAX) : CNT_W'(cap_q);
	assign len     = CNT_W'(cmd.length);
	assign peek_n  = (len < cnt_q) ? len : cnt_q;

	always_comb begin
		head_n      = head_q;
		cnt_n       = cnt_q;
		wtot_n      = wtot_q;
		rtot_n      = rtot_q;
		closed_n    = closed_q;
		err_n       = err_q;
		lock_set    = 1'b0;
		wr.en       = 1'b0;
		wr.addr     = head_q + cnt_q[ADDR_W-1:0];
		wr.data     = cmd.byte_in;
		job.run     = 1'b0;
		job.is_read = 1'b0;
		job.start   = head_q;
		job.n       = '0;
		job.status  = ST_OK;
		unique case (cmd.action)
			ACT_WRITE: begin
				if (err_q) begin
					job.status = ST_STICKY;
				end else if (closed_q) begin
					job.status = ST_CLOSED;
				end else if (cnt_q >= eff_cap) begin
					job.status = ST_FULL;
				end else begin
					wr.en  = push;
					cnt_n  = cnt_q + CNT_W'(1);
					wtot_n = wtot_q + TOT_W'(1);
				end
			end
			ACT_PEEK: begin
				if (err_q) begin
					job.status = ST_STICKY;
				end else begin
					job.run = (peek_n != '0);
					job.n   = peek_n;
				end
			end
			ACT_POP, ACT_READ: begin
				if (err_q) begin
					job.status = ST_STICKY;
				end else if (len > cnt_q) begin
					err_n      = 1'b1;
					job.status = ST_UNDERFLOW;
				end else begin
					head_n = head_q + len[ADDR_W-1:0];
					cnt_n  = cnt_q - len;
					rtot_n = rtot_q + TOT_W'(len);
					// a read run frees slots it still has to read out
					if (cmd.action == ACT_READ && len != '0) begin
						job.run     = 1'b1;
						job.is_read = 1'b1;
						job.n       = len;
						lock_set    = 1'b1;
					end
				end
			end
			ACT_END: begin
				closed_n = 1'b1;
			end
			default: begin
			end
		endcase
		job.occupancy     = 7'(cnt_n);
		job.space_left    = (eff_cap > cnt_n) ? 7'(eff_cap - cnt_n) : 7'd0;
		job.total_written = wtot_n;
		job.total_read    = rtot_n;
		job.input_closed  = closed_n;
		job.end_of_stream = closed_n && (cnt_n == '0);
		job.error_flag    = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CFG_W'(CAPACITY_MAX);
			head_q   <= '0;
			cnt_q    <= '0;
			wtot_q   <= '0;
			rtot_q   <= '0;
			closed_q <= 1'b0;
			err_q    <= 1'b0;
			lock_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (push) begin
				head_q   <= head_n;
				cnt_q    <= cnt_n;
				wtot_q   <= wtot_n;
				rtot_q   <= rtot_n;
				closed_q <= closed_n;
				err_q    <= err_n;
			end
			if (push && lock_set) begin
				lock_q <= 1'b1;
			end else if (back_stat.read_done) begin
				lock_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/bbsf_back.sv
// back end: byte store and result sequencing, one result per cycle
module bbsf_back import bbsf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  bbsf_wr_t        wr,
	input  logic            q_valid,
	input  bbsf_job_t       q_job,
	output logic            q_pop,
	output bbsf_back_stat_t back_stat,
	output logic            strobe,
	output bbsf_result_t    result
);

	logic [7:0]        mem [CAPACITY_MAX];
	logic              active_q;
	logic [CNT_W-1:0]  idx_q;
	bbsf_job_t         cur_q;

	logic              strobe_s1;
	logic              bv_s1;
	logic              last_s1;
	bbsf_job_t         snap_s1;
	logic [7:0]        rdata_s1;

	bbsf_job_t         emit_job;
	logic [CNT_W-1:0]  emit_idx;
	logic              emit;
	logic              elem_last;
	logic [ADDR_W-1:0] rd_addr;

	assign q_pop = !active_q && q_valid;
	assign emit  = active_q || q_pop;

	always_comb begin
		if (active_q) begin
			emit_job = cur_q;
			emit_idx = idx_q;
		end else begin
			emit_job = q_job;
			emit_idx = '0;
		end
		elem_last = !emit_job.run || (emit_idx == emit_job.n - CNT_W'(1));
		rd_addr   = emit_job.start + emit_idx[ADDR_W-1:0];
	end

	assign back_stat.read_done = emit && emit_job.run && emit_job.is_read && elem_last;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_s1 <= mem[rd_addr];
		if (emit) begin
			snap_s1 <= emit_job;
		end
		if (q_pop) begin
			cur_q <= q_job;
		end
		idx_q <= emit_idx + CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			strobe_s1 <= 1'b0;
			bv_s1     <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			active_q  <= emit && emit_job.run && !elem_last;
			strobe_s1 <= emit;
			bv_s1     <= emit && emit_job.run;
			last_s1   <= elem_last;
		end
	end

	assign strobe               = strobe_s1;
	assign result.byte_out      = bv_s1 ? rdata_s1 : 8'd0;
	assign result.byte_valid    = bv_s1;
	assign result.last          = last_s1;
	assign result.status        = snap_s1.status;
	assign result.occupancy     = snap_s1.occupancy;
	assign result.space_left    = snap_s1.space_left;
	assign result.total_written = snap_s1.total_written;
	assign result.total_read    = snap_s1.total_read;
	assign result.input_closed  = snap_s1.input_closed;
	assign result.end_of_stream = snap_s1.end_of_stream;
	assign result.error_flag    = snap_s1.error_flag;

endmodule

>>> sv/bounded_byte_stream_fifo.sv
// top level of the bounded byte stream fifo
// a request (cmd) is taken at a rising edge with start high and busy low.
// actions: write one byte, peek, pop, read, end input, status query.
// every request gives at least one result on result, marked by strobe for
// one cycle; the receiver cannot stall it. peek and read give one result per
// byte with last on the final one, every other request a single result.
// the first result of a request leaves through the job queue and the back end's
// output register; results stream one per cycle.
// single-result requests are taken one per cycle while busy is low; a run of
// bytes holds the back end, limited by the one store read port,
// while the two-entry job queue lets the front keep taking requests.
// after a read with bytes, busy stays high until its last byte is read out
// of the store, since later writes may reuse the freed slots.
// capacity is written through cfg_we/cfg_data while idle; values above 64
// act as 64. reset clears counts, totals, flags and sets capacity to 64;
// the store itself is not cleared, only written bytes are ever returned.
module bounded_byte_stream_fifo import bbsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bbsf_cmd_t        cmd,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             strobe,
	output bbsf_result_t     result
);

	logic            q_full;
	logic            q_not_empty;
	logic            q_pop;
	logic            push;
	bbsf_job_t       push_job;
	bbsf_job_t       head_job;
	bbsf_wr_t        wr;
	bbsf_back_stat_t back_stat;

	bbsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.back_stat (back_stat),
		.busy      (busy),
		.push      (push),
		.job       (push_job),
		.wr        (wr)
	);

	bbsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (q_pop),
		.head_job  (head_job),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	bbsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.q_valid   (q_not_empty),
		.q_job     (head_job),
		.q_pop     (q_pop),
		.back_stat (back_stat),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the bounded byte stream fifo: directed table, random phases, shutdown
`timescale 1ns / 100ps

module tb_top;
	import bbsf_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int         PHASES     = 6;
	localparam int         PHASE_LEN  = 22;

	typedef struct {
		bbsf_cmd_t  cmd;
		bit         typed;
		logic [2:0] st;
		logic [6:0] occ;
	} table_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	bbsf_cmd_t        cmd = '0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             strobe;
	bbsf_result_t     result;

	// fifo predictor state
	logic [7:0]        fifo_mem [0:CAPACITY_MAX-1];
	logic [ADDR_W-1:0] head_ptr = '0;
	logic [6:0]        held = '0;
	logic [TOT_W-1:0]  bytes_in_total = '0;
	logic [TOT_W-1:0]  bytes_out_total = '0;
	logic              in_closed = 1'b0;
	logic              err_sticky = 1'b0;
	logic [CFG_W-1:0]  capacity = 7'd64;

	bbsf_result_t pending_results[$];
	bbsf_result_t oldest;
	table_row_t   opening_rows[$];
	int           fail_count = 0;

	int phase_cap  [PHASES] = '{64, 127, 3, 0, 1, 40};
	int phase_wr   [PHASES] = '{70, 45, 50, 30, 55, 50};
	int phase_idle [PHASES] = '{0, 82, 24, 0, 82, 24};

	bounded_byte_stream_fifo DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.strobe   (strobe),
		.result   (result)
	);

	always #2 clk = ~clk;

	function automatic logic [6:0] eff_cap();
		return (capacity > CAPACITY_MAX) ? 7'(CAPACITY_MAX) : capacity;
	endfunction

	function automatic bbsf_result_t snapshot(input logic [7:0] b, input logic v, input logic l,
			input logic [2:0] st);
		bbsf_result_t r;
		r.byte_out      = b;
		r.byte_valid    = v;
		r.last          = l;
		r.status        = st;
		r.occupancy     = held;
		r.space_left    = (eff_cap() > held) ? eff_cap() - held : 7'd0;
		r.total_written = bytes_in_total;
		r.total_read    = bytes_out_total;
		r.input_closed  = in_closed;
		r.end_of_stream = in_closed && (held == 0);
		r.error_flag    = err_sticky;
		return r;
	endfunction

	function automatic void queue_result(input bbsf_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	task automatic predict_fifo_request(input bbsf_cmd_t c);
		logic [6:0]        n;
		logic [ADDR_W-1:0] slot;
		case (c.action)
		ACT_WRITE: begin
			if (err_sticky)
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_STICKY));
			else if (in_closed)
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_CLOSED));
			else if (held >= eff_cap())
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_FULL));
			else begin
				slot = head_ptr + held[ADDR_W-1:0];
				fifo_mem[slot] = c.byte_in;
				held = held + 7'd1;
				bytes_in_total = bytes_in_total + 1;
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_OK));
			end
		end
		ACT_PEEK: begin
			n = (c.length < held) ? c.length : held;
			if (err_sticky)
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_STICKY));
			else if (n == 0)
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_OK));
			else begin
				slot = head_ptr;
				for (int i = 0; i < n; i++) begin
					queue_result(snapshot(fifo_mem[slot], 1'b1, i + 1 == n, ST_OK));
					slot = slot + 1'b1;
				end
			end
		end
		ACT_POP, ACT_READ: begin
			if (err_sticky)
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_STICKY));
			else if (c.length > held) begin
				// underflow removes nothing but latches the error
				err_sticky = 1'b1;
				queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_UNDERFLOW));
			end else begin
				slot = head_ptr;
				head_ptr = head_ptr + c.length[ADDR_W-1:0];
				held = held - c.length;
				bytes_out_total = bytes_out_total + c.length;
				if (c.action == ACT_POP || c.length == 0)
					queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_OK));
				else begin
					for (int i = 0; i < c.length; i++) begin
						queue_result(snapshot(fifo_mem[slot], 1'b1,
							i + 1 == c.length, ST_OK));
						slot = slot + 1'b1;
					end
				end
			end
		end
		ACT_END: begin
			in_closed = 1'b1;
			queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_OK));
		end
		default: begin
			queue_result(snapshot(8'h00, 1'b0, 1'b1, ST_OK));
		end
		endcase
	endtask

	function automatic bbsf_cmd_t make_request(input logic [2:0] act, input logic [7:0] b,
			input logic [6:0] len);
		bbsf_cmd_t c;
		c.action  = act;
		c.byte_in = b;
		c.length  = len;
		return c;
	endfunction

	// mostly well-formed traffic: pops and reads never ask for more than is held
	function automatic bbsf_cmd_t random_request(input int wr_pct);
		bbsf_cmd_t c;
		int        pick;
		c = make_request(ACT_WRITE, 8'($urandom), 7'($urandom));
		if ($urandom_range(0, 99) >= wr_pct) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				c.action = ACT_PEEK;
				if ($urandom_range(0, 1))
					c.length = 7'($urandom_range(0, held));
			end else if (pick < 8) begin
				c.action = (pick < 5) ? ACT_POP : ACT_READ;
				c.length = 7'($urandom_range(0, held));
			end else if (pick == 8)
				c.action = ACT_QUERY;
			else
				c.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
		end
		return c;
	endfunction

	task automatic issue(input bbsf_cmd_t c, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		predict_fifo_request(c);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		capacity = v;
	endtask

	task automatic add_row(input logic [2:0] act, input logic [7:0] b, input logic [6:0] len,
			input bit typed, input logic [2:0] st, input logic [6:0] occ);
		table_row_t row;
		row.cmd   = make_request(act, b, len);
		row.typed = typed;
		row.st    = st;
		row.occ   = occ;
		opening_rows.insert(opening_rows.size(), row);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (strobe === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request waiting, actual %h", $time, result);
				fail_count++;
			end else begin
				oldest = pending_results[0];
				pending_results.delete(0);
				compare_field("byte_out", 64'(oldest.byte_out), 64'(result.byte_out));
				compare_field("byte_valid", 64'(oldest.byte_valid), 64'(result.byte_valid));
				compare_field("last", 64'(oldest.last), 64'(result.last));
				compare_field("status", 64'(oldest.status), 64'(result.status));
				compare_field("occupancy", 64'(oldest.occupancy), 64'(result.occupancy));
				compare_field("space_left", 64'(oldest.space_left), 64'(result.space_left));
				compare_field("total_written", oldest.total_written, result.total_written);
				compare_field("total_read", oldest.total_read, result.total_read);
				compare_field("input_closed", 64'(oldest.input_closed),
					64'(result.input_closed));
				compare_field("end_of_stream", 64'(oldest.end_of_stream),
					64'(result.end_of_stream));
				compare_field("error_flag", 64'(oldest.error_flag), 64'(result.error_flag));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("bounded_byte_stream_fifo test failed");
		$finish;
	end

	initial begin
		add_row(ACT_QUERY, 8'h00, 7'd0, 1, ST_OK, 7'd0);
		add_row(ACT_PEEK, 8'h00, 7'd0, 1, ST_OK, 7'd0);
		add_row(ACT_PEEK, 8'hFF, 7'd127, 1, ST_OK, 7'd0);
		add_row(ACT_READ, 8'h00, 7'd0, 1, ST_OK, 7'd0);
		add_row(ACT_POP, 8'h00, 7'd0, 1, ST_OK, 7'd0);
		add_row(ACT_WRITE, 8'h00, 7'd127, 1, ST_OK, 7'd1);
		add_row(ACT_WRITE, 8'hFF, 7'd0, 1, ST_OK, 7'd2);
		add_row(ACT_WRITE, 8'hA5, 7'd0, 1, ST_OK, 7'd3);
		add_row(ACT_WRITE, 8'h5A, 7'd0, 1, ST_OK, 7'd4);
		add_row(ACT_PEEK, 8'h00, 7'd2, 0, ST_OK, 7'd0);
		add_row(ACT_PEEK, 8'h00, 7'd127, 0, ST_OK, 7'd0);
		add_row(ACT_READ, 8'h00, 7'd0, 1, ST_OK, 7'd4);
		add_row(ACT_READ, 8'h00, 7'd1, 0, ST_OK, 7'd0);
		add_row(ACT_POP, 8'h00, 7'd1, 1, ST_OK, 7'd2);
		add_row(ACT_SPARE6, 8'hFF, 7'd127, 1, ST_OK, 7'd2);
		add_row(ACT_SPARE7, 8'h00, 7'd0, 1, ST_OK, 7'd2);
		add_row(ACT_PEEK, 8'h00, 7'd64, 0, ST_OK, 7'd0);
		add_row(ACT_READ, 8'h00, 7'd2, 0, ST_OK, 7'd0);
		add_row(ACT_WRITE, 8'h80, 7'd0, 0, ST_OK, 7'd0);
		add_row(ACT_WRITE, 8'h01, 7'd0, 0, ST_OK, 7'd0);
		add_row(ACT_WRITE, 8'h7F, 7'd0, 0, ST_OK, 7'd0);
		add_row(ACT_READ, 8'h00, 7'd3, 0, ST_OK, 7'd0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// typed rows give a single result, the newest entry of the queue
		foreach (opening_rows[r]) begin
			issue(opening_rows[r].cmd, 0);
			if (opening_rows[r].typed) begin
				pending_results[pending_results.size() - 1].status    = opening_rows[r].st;
				pending_results[pending_results.size() - 1].occupancy = opening_rows[r].occ;
			end
		end

		// capacity moves between phases, including zero, saturation and below occupancy
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_capacity(7'(phase_cap[p]));
			for (int k = 0; k < PHASE_LEN; k++)
				issue(random_request(phase_wr[p]), phase_idle[p]);
		end

		// shutdown: fill, close, drain to end of stream, then latch the error
		wait_idle();
		write_capacity(7'd4);
		while (held < eff_cap())
			issue(make_request(ACT_WRITE, 8'($urandom), 7'd0), 24);
		issue(make_request(ACT_WRITE, 8'hFF, 7'd127), 0);
		issue(make_request(ACT_END, 8'h00, 7'd0), 0);
		// closed outranks full
		issue(make_request(ACT_WRITE, 8'h00, 7'd0), 0);
		issue(make_request(ACT_PEEK, 8'h00, 7'd127), 0);
		issue(make_request(ACT_READ, 8'h00, held), 82);
		issue(make_request(ACT_QUERY, 8'h00, 7'd0), 0);
		issue(make_request(ACT_READ, 8'h00, 7'd127), 0);
		// sticky error outranks closed
		issue(make_request(ACT_WRITE, 8'h3C, 7'd0), 0);
		issue(make_request(ACT_PEEK, 8'h00, 7'd1), 0);
		issue(make_request(ACT_POP, 8'h00, 7'd0), 0);
		issue(make_request(ACT_READ, 8'h00, 7'd0), 0);
		issue(make_request(ACT_END, 8'h00, 7'd0), 0);
		for (int k = 0; k < 12; k++)
			issue(make_request(3'($urandom), 8'($urandom), 7'($urandom)), 24);

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("bounded_byte_stream_fifo test passed");
		else
			$display("bounded_byte_stream_fifo test failed");
		$finish;
	end

endmodule
